// File: design/pgf_pkg.sv
// pgf_pkg: shared widths and reset constants for the pairwise gravity force core
// used by pairwise_gravity_force_core; no dependencies
package pgf_pkg;

    localparam int POS_W   = 32;                 // signed position field
    localparam int MASS_W  = 32;                 // unsigned mass field
    localparam int G_W     = 32;                 // gravity constant register
    localparam int DIFF_W  = 33;                 // |second - first| magnitude
    localparam int R2_W    = 2 * DIFF_W;         // squared distance
    localparam int ROOT_W  = R2_W / 2;           // floor of the distance
    localparam int PROD_W  = G_W + 2 * MASS_W;   // G * ma * mb
    localparam int MAG_W   = 64;                 // clamped force magnitude
    localparam int NUM_W   = MAG_W + DIFF_W;     // magnitude times |d|
    localparam int FORCE_W = 32;                 // signed force component
    localparam int IN_W    = 4 * POS_W + 2 * MASS_W;
    localparam int OUT_W   = 2 * FORCE_W;
    localparam int USER_W  = 2;

    localparam logic [G_W-1:0] G_RESET = 32'd65536;

    // flag positions in the result tuser
    localparam int USER_COINCIDENT = 0;
    localparam int USER_SATURATED  = 1;

endpackage

// File: design/pairwise_gravity_force_core.sv
// pairwise_gravity_force_core: top level, Newtonian pair force in fixed point
// depends on pgf_pkg, pgf_sqrt and pgf_div
//
// Takes one word per cycle unless stalled, holding two body positions and
// masses, and returns the force on the first body toward the second,
// G*ma*mb/|d|^2 along d/|d|, each component truncated toward zero and clamped
// to 32 signed bits. The pipeline accepts a new word every cycle unless
// stalled; it holds the 33-stage square root, the 64-stage magnitude divider
// and the 32-stage component dividers, one quotient bit per stage. A two-entry
// output buffer keeps the pipe moving while one result waits; the input stalls
// only when both entries are full. Equal positions give zero force with the
// coincident flag. gravity_constant is written through cfg_wen/cfg_wdata; the
// user must write it only while no word is in flight; the block does not check.
module pairwise_gravity_force_core #(
    parameter int IN_W   = pgf_pkg::IN_W,
    parameter int OUT_W  = pgf_pkg::OUT_W,
    parameter int USER_W = pgf_pkg::USER_W
) (
    input  logic              clk,
    input  logic              rst_n,
    // slave: first_pos_x, first_pos_y, second_pos_x, second_pos_y,
    //        first_mass, second_mass (32 bits each)
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    // master data: force_x, force_y (32 bits each)
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,
    // master user: coincident, saturated
    output logic [USER_W-1:0] m_axis_tuser,
    // gravity constant, unsigned Q16.16
    input  logic              cfg_wen,
    input  logic [pgf_pkg::G_W-1:0] cfg_wdata
);

    localparam int DW   = pgf_pkg::DIFF_W;
    localparam int R2W  = pgf_pkg::R2_W;
    localparam int RW   = pgf_pkg::ROOT_W;
    localparam int PW   = pgf_pkg::PROD_W;
    localparam int MW   = pgf_pkg::MAG_W;
    localparam int NW   = pgf_pkg::NUM_W;
    localparam int FW   = pgf_pkg::FORCE_W;
    localparam int HALF = MW / 2;
    localparam int SQ_SIDE_W  = PW + R2W + 2 * DW + 3;
    localparam int DV1_SIDE_W = RW + 2 * DW + 4;

    // gravity constant register
    logic [pgf_pkg::G_W-1:0] g_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            g_reg <= pgf_pkg::G_RESET;
        end
        else if (cfg_wen) begin
            g_reg <= cfg_wdata;
        end
    end

    // whole pipe advances together, frozen only while the skid entry is full
    logic en;
    logic skid_valid_reg;
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // input unpack
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        adx_next, ady_next;
    logic [pgf_pkg::MASS_W-1:0] ma, mb;

    assign dx = $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
              - $signed({s_axis_tdata[31], s_axis_tdata[31:0]});
    assign dy = $signed({s_axis_tdata[127], s_axis_tdata[127:96]})
              - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
    assign ma = s_axis_tdata[159:128];
    assign mb = s_axis_tdata[191:160];
    assign adx_next = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady_next = dy[DW-1] ? DW'(-dy) : DW'(dy);

    // stage 1: differences, magnitudes, G * ma
    logic          v1_reg;
    logic [DW-1:0] adx1_reg, ady1_reg;
    logic          negx1_reg, negy1_reg, coin1_reg;
    logic [MW-1:0] gma1_reg;
    logic [pgf_pkg::MASS_W-1:0] mb1_reg;

    // stage 2: squares and the two halves of G * ma * mb
    logic           v2_reg;
    logic [R2W-1:0] sqx2_reg, sqy2_reg;
    logic [MW-1:0]  plo2_reg, phi2_reg;
    logic [DW-1:0]  adx2_reg, ady2_reg;
    logic           negx2_reg, negy2_reg, coin2_reg;

    // stage 3: squared distance and full mass product
    logic           v3_reg;
    logic [R2W-1:0] r2_3_reg;
    logic [PW-1:0]  p3_reg;
    logic [DW-1:0]  adx3_reg, ady3_reg;
    logic           negx3_reg, negy3_reg, coin3_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            adx1_reg  <= adx_next;
            ady1_reg  <= ady_next;
            negx1_reg <= dx[DW-1];
            negy1_reg <= dy[DW-1];
            coin1_reg <= (dx == '0) && (dy == '0);
            gma1_reg  <= MW'(g_reg) * MW'(ma);
            mb1_reg   <= mb;

            sqx2_reg  <= R2W'(adx1_reg) * R2W'(adx1_reg);
            sqy2_reg  <= R2W'(ady1_reg) * R2W'(ady1_reg);
            plo2_reg  <= MW'(gma1_reg[HALF-1:0]) * MW'(mb1_reg);
            phi2_reg  <= MW'(gma1_reg[MW-1:HALF]) * MW'(mb1_reg);
            adx2_reg  <= adx1_reg;
            ady2_reg  <= ady1_reg;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            coin2_reg <= coin1_reg;

            r2_3_reg  <= sqx2_reg + sqy2_reg;
            p3_reg    <= {phi2_reg, {HALF{1'b0}}} + PW'(plo2_reg);
            adx3_reg  <= adx2_reg;
            ady3_reg  <= ady2_reg;
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;
            coin3_reg <= coin2_reg;
        end
    end

    // distance: floor(sqrt(r2))
    logic                 sq_valid;
    logic [RW-1:0]        sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;

    pgf_sqrt #(
        .IN_W   (R2W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_val    (r2_3_reg),
        .in_side   ({p3_reg, r2_3_reg, adx3_reg, ady3_reg, negx3_reg, negy3_reg,
                     coin3_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic [PW-1:0]  sq_p;
    logic [R2W-1:0] sq_r2;
    logic [DW-1:0]  sq_adx, sq_ady;
    logic           sq_negx, sq_negy, sq_coin;

    assign {sq_p, sq_r2, sq_adx, sq_ady, sq_negx, sq_negy, sq_coin} = sq_side;

    // stage 4: magnitude overflow check, quotient at or above 2^64
    logic           v4_reg;
    logic [RW-1:0]  r4_reg;
    logic [PW-1:0]  p4_reg;
    logic [R2W-1:0] r2_4_reg;
    logic [DW-1:0]  adx4_reg, ady4_reg;
    logic           negx4_reg, negy4_reg, coin4_reg, ovf4_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v4_reg <= 1'b0;
        end
        else if (en) begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            r4_reg    <= sq_root;
            p4_reg    <= sq_p;
            r2_4_reg  <= sq_r2;
            adx4_reg  <= sq_adx;
            ady4_reg  <= sq_ady;
            negx4_reg <= sq_negx;
            negy4_reg <= sq_negy;
            coin4_reg <= sq_coin;
            ovf4_reg  <= (R2W'(sq_p[PW-1:MW]) >= sq_r2);
        end
    end

    // magnitude m = floor(p / r2), low 64 quotient bits
    logic                  dv1_valid;
    logic [MW-1:0]         dv1_quo;
    logic [DV1_SIDE_W-1:0] dv1_side;

    pgf_div #(
        .QUO_W  (MW),
        .DEN_W  (R2W),
        .SIDE_W (DV1_SIDE_W)
    ) u_div_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rem    (ovf4_reg ? '0 : R2W'(p4_reg[PW-1:MW])),
        .in_num    (p4_reg[MW-1:0]),
        .in_den    (r2_4_reg),
        .in_side   ({r4_reg, adx4_reg, ady4_reg, negx4_reg, negy4_reg, coin4_reg,
                     ovf4_reg}),
        .out_valid (dv1_valid),
        .out_quo   (dv1_quo),
        .out_side  (dv1_side)
    );

    logic [RW-1:0] d1_r;
    logic [DW-1:0] d1_adx, d1_ady;
    logic          d1_negx, d1_negy, d1_coin, d1_ovf;
    logic [MW-1:0] mag;

    assign {d1_r, d1_adx, d1_ady, d1_negx, d1_negy, d1_coin, d1_ovf} = dv1_side;
    assign mag = d1_ovf ? '1 : dv1_quo;

    // stage 5: m * |d| partial products, stage 6: their sums
    logic          v5_reg, v6_reg, v7_reg;
    logic [HALF+DW-1:0] mxl5_reg, mxh5_reg, myl5_reg, myh5_reg;
    logic [RW-1:0] r5_reg, r6_reg, r7_reg;
    logic          negx5_reg, negy5_reg, coin5_reg;
    logic [NW-1:0] nx6_reg, ny6_reg;
    logic          negx6_reg, negy6_reg, coin6_reg;

    // stage 7: component saturation check, quotient at or above 2^32
    logic [NW-1:0] nx7_reg, ny7_reg;
    logic          negx7_reg, negy7_reg, coin7_reg, satpx7_reg, satpy7_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en) begin
            v5_reg <= dv1_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mxl5_reg  <= (HALF+DW)'(mag[HALF-1:0]) * (HALF+DW)'(d1_adx);
            mxh5_reg  <= (HALF+DW)'(mag[MW-1:HALF]) * (HALF+DW)'(d1_adx);
            myl5_reg  <= (HALF+DW)'(mag[HALF-1:0]) * (HALF+DW)'(d1_ady);
            myh5_reg  <= (HALF+DW)'(mag[MW-1:HALF]) * (HALF+DW)'(d1_ady);
            r5_reg    <= d1_r;
            negx5_reg <= d1_negx;
            negy5_reg <= d1_negy;
            coin5_reg <= d1_coin;

            nx6_reg   <= {mxh5_reg, {HALF{1'b0}}} + NW'(mxl5_reg);
            ny6_reg   <= {myh5_reg, {HALF{1'b0}}} + NW'(myl5_reg);
            r6_reg    <= r5_reg;
            negx6_reg <= negx5_reg;
            negy6_reg <= negy5_reg;
            coin6_reg <= coin5_reg;

            nx7_reg    <= nx6_reg;
            ny7_reg    <= ny6_reg;
            r7_reg     <= r6_reg;
            negx7_reg  <= negx6_reg;
            negy7_reg  <= negy6_reg;
            coin7_reg  <= coin6_reg;
            satpx7_reg <= (nx6_reg[NW-1:FW] >= (NW-FW)'(r6_reg));
            satpy7_reg <= (ny6_reg[NW-1:FW] >= (NW-FW)'(r6_reg));
        end
    end

    // components floor(m * |d| / r), x carries the shared flags
    logic          dvx_valid, dvy_valid;
    logic [FW-1:0] qx, qy;
    logic [3:0]    dvx_side;
    logic          dvy_side;

    pgf_div #(
        .QUO_W  (FW),
        .DEN_W  (RW),
        .SIDE_W (4)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rem    (satpx7_reg ? '0 : nx7_reg[FW +: RW]),
        .in_num    (nx7_reg[FW-1:0]),
        .in_den    (r7_reg),
        .in_side   ({coin7_reg, negy7_reg, negx7_reg, satpx7_reg}),
        .out_valid (dvx_valid),
        .out_quo   (qx),
        .out_side  (dvx_side)
    );

    pgf_div #(
        .QUO_W  (FW),
        .DEN_W  (RW),
        .SIDE_W (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rem    (satpy7_reg ? '0 : ny7_reg[FW +: RW]),
        .in_num    (ny7_reg[FW-1:0]),
        .in_den    (r7_reg),
        .in_side   (satpy7_reg),
        .out_valid (dvy_valid),
        .out_quo   (qy),
        .out_side  (dvy_side)
    );

    // final clamp, sign and coincident override
    logic          f_coin, f_negy, f_negx, f_satpx, f_satpy;
    logic [FW-1:0] limx, limy, magx, magy, fx, fy;
    logic          satx, saty;
    logic [OUT_W-1:0]  res_data;
    logic [USER_W-1:0] res_user;

    assign {f_coin, f_negy, f_negx, f_satpx} = dvx_side;
    assign f_satpy = dvy_side;
    // most negative value has one more unit of magnitude
    assign limx = f_negx ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    assign limy = f_negy ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    assign satx = f_satpx || (qx > limx);
    assign saty = f_satpy || (qy > limy);
    assign magx = satx ? limx : qx;
    assign magy = saty ? limy : qy;
    assign fx   = f_negx ? (~magx + 1'b1) : magx;
    assign fy   = f_negy ? (~magy + 1'b1) : magy;

    always_comb begin
        res_data = {fy, fx};
        res_user = '0;
        res_user[pgf_pkg::USER_SATURATED] = satx || saty;
        if (f_coin) begin
            res_data = '0;
            res_user = '0;
            res_user[pgf_pkg::USER_COINCIDENT] = 1'b1;
        end
    end

    // output register plus one skid entry
    logic              push, take;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, skid_data_reg;
    logic [USER_W-1:0] out_user_reg, skid_user_reg;

    assign push = en && dvx_valid;
    assign take = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push) begin
            if (out_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end
            else begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (push) begin
            if (out_valid_reg && !take) begin
                skid_data_reg <= res_data;
                skid_user_reg <= res_user;
            end
            else begin
                out_data_reg <= res_data;
                out_user_reg <= res_user;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // skid entry only fills behind a waiting output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_axis_tvalid)
        else $error("skid entry full with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid entry filled while output was free");

    // coincident words carry zero force and no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[pgf_pkg::USER_COINCIDENT])
        |-> (m_axis_tdata == '0) && !m_axis_tuser[pgf_pkg::USER_SATURATED])
        else $error("coincident word with nonzero force");

    // x and y component dividers stay in lockstep
    assert property (@(posedge clk) disable iff (!rst_n)
        dvx_valid == dvy_valid)
        else $error("component dividers out of step");

endmodule

// File: design/pgf_sqrt.sv
// pgf_sqrt: pipelined integer square root, one result bit per register stage
// uses no package; sideband payload travels with each word
module pgf_sqrt #(
    parameter int IN_W   = 66,   // even width of the radicand
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [IN_W-1:0]           in_val,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [IN_W/2-1:0]         out_root,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic              vld_reg  [1:ROOT_W];
    logic [IN_W-1:0]   v_reg    [1:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];
    logic [SIDE_W-1:0] side_reg [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              cur_vld;
        logic [IN_W-1:0]   cur_v;
        logic [REM_W-1:0]  cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [SIDE_W-1:0] cur_side;
        logic [REM_W-1:0]  rem2;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_v    = in_val;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_side = in_side;
        end
        else begin : g_next
            assign cur_vld  = vld_reg[k];
            assign cur_v    = v_reg[k];
            assign cur_rem  = rem_reg[k];
            assign cur_root = root_reg[k];
            assign cur_side = side_reg[k];
        end

        // bring down two radicand bits, try appending a one to the root
        assign rem2  = {cur_rem[REM_W-3:0], cur_v[IN_W-1 -: 2]};
        assign trial = {1'b0, cur_root, 2'b01};
        assign ge    = (rem2 >= trial);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en) begin
                vld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                v_reg[k+1]    <= {cur_v[IN_W-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? (rem2 - trial) : rem2;
                root_reg[k+1] <= {cur_root[ROOT_W-2:0], ge};
                side_reg[k+1] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

// File: design/pgf_div.sv
// pgf_div: pipelined restoring divider, one quotient bit per register stage
// uses no package; caller supplies a starting remainder below the divisor
module pgf_div #(
    parameter int QUO_W  = 32,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DEN_W-1:0]     in_rem,
    input  logic [QUO_W-1:0]     in_num,
    input  logic [DEN_W-1:0]     in_den,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [QUO_W-1:0]     out_quo,
    output logic [SIDE_W-1:0]    out_side
);

    logic              vld_reg  [1:QUO_W];
    logic [DEN_W-1:0]  rem_reg  [1:QUO_W];
    logic [QUO_W-1:0]  num_reg  [1:QUO_W];
    logic [DEN_W-1:0]  den_reg  [1:QUO_W];
    logic [SIDE_W-1:0] side_reg [1:QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic              cur_vld;
        logic [DEN_W-1:0]  cur_rem;
        logic [QUO_W-1:0]  cur_num;
        logic [DEN_W-1:0]  cur_den;
        logic [SIDE_W-1:0] cur_side;
        logic [DEN_W:0]    rem2;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = in_rem;
            assign cur_num  = in_num;
            assign cur_den  = in_den;
            assign cur_side = in_side;
        end
        else begin : g_next
            assign cur_vld  = vld_reg[k];
            assign cur_rem  = rem_reg[k];
            assign cur_num  = num_reg[k];
            assign cur_den  = den_reg[k];
            assign cur_side = side_reg[k];
        end

        // numerator shifts out the top, quotient bits shift in below
        assign rem2 = {cur_rem, cur_num[QUO_W-1]};
        assign diff = rem2 - {1'b0, cur_den};
        assign ge   = (rem2 >= {1'b0, cur_den});

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en) begin
                vld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
                num_reg[k+1]  <= {cur_num[QUO_W-2:0], ge};
                den_reg[k+1]  <= cur_den;
                side_reg[k+1] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_quo   = num_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule
